// File: design/chmc_pkg.sv
// ---------------------------------------------------------------------------
// chmc_pkg
// shared widths and types for the monotone chain hull block
// ---------------------------------------------------------------------------
package chmc_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_BITS_DEF = 16;
  localparam int IDX_W          = 5;
  localparam int X_W            = 16;

  typedef struct packed {
    logic signed [X_W-1:0] hull_x;
    logic signed [X_W-1:0] hull_y;
    logic [IDX_W-1:0]      hull_index;
    logic                  hull_empty;
    logic                  overflow;
    logic                  last_result;
  } res_t;

  // per-cell shift control
  typedef struct packed {
    logic shift;   // open a slot at or above the insert position
    logic clear;   // drop all valid bits
  } cell_ctl_t;

endpackage

// File: design/chmc_if.sv
// ---------------------------------------------------------------------------
// chmc_in_if / chmc_out_if
// valid/ready channels for points and hull results
// ---------------------------------------------------------------------------
interface chmc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic               last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface chmc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hull_x;
  logic signed [15:0] hull_y;
  logic [4:0]         hull_index;
  logic               hull_empty;
  logic               overflow;
  logic               last_result;
  modport source (output valid, hull_x, hull_y, hull_index, hull_empty, overflow,
                  last_result, input ready);
  modport sink   (input valid, hull_x, hull_y, hull_index, hull_empty, overflow,
                  last_result, output ready);
endinterface

// File: design/convex_hull_monotone_chain.sv
// Convex hull by monotone chain. Points load one per cycle into a row of
// cells that keeps them sorted by x then y (an insertion shift across the row
// in that cycle). After the last point the hull runs a lower then an upper
// pass over a stack held in a memory with registered reads. Each cross
// product test has an operand fetch, two 17x17 multiplies and a compare; a pop
// adds a stack read, and a push adds a write and a stack read. Result words then
// go out one per cycle while the sink is ready; input is held off until the
// last result is taken.
module convex_hull_monotone_chain #(
  parameter int MAX_POINTS = chmc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chmc_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  chmc_in_if.sink    in_ch,
  chmc_out_if.source out_ch
);
  import chmc_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PI_W  = $clog2(MAX_POINTS);
  localparam int SD    = 2 * MAX_POINTS;
  localparam int SP_W  = $clog2(SD + 1);
  localparam int SA_W  = $clog2(SD);
  localparam int CW    = COORD_BITS;

  localparam logic [2:0] S_LOAD = 3'd0, S_FETCH = 3'd1, S_MUL = 3'd2,
                         S_DEC  = 3'd3, S_EMIT = 3'd4, S_OUT = 3'd5,
                         S_RD   = 3'd6;

  logic [2:0]        state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic              upper_r;
  logic [CNT_W-1:0]  i_r;        // position in sorted row
  logic [SP_W-1:0]   k_r, bound_r, e_r;
  logic [PI_W-1:0]   stk_r [SD];
  logic signed [CW:0] ax_r, ay_r, bx_r, by_r;
  logic signed [2*CW+1:0] p1_r, p2_r;
  logic              empty_r;

  // sorted row
  logic signed [CW-1:0] cx [MAX_POINTS];
  logic signed [CW-1:0] cy [MAX_POINTS];
  logic [IDX_W-1:0]     ci [MAX_POINTS];
  logic                 cv [MAX_POINTS];
  logic                 ca [MAX_POINTS];
  logic                 load, clr;

  // load-order store for coordinate lookup by index
  logic signed [CW-1:0] sx_r [MAX_POINTS];
  logic signed [CW-1:0] sy_r [MAX_POINTS];

  assign load = in_ch.valid && in_ch.ready && (cnt_r < CNT_W'(MAX_POINTS));

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_row
    logic signed [CW-1:0] bxw, byw;
    logic [IDX_W-1:0]     biw;
    logic                 baw, bvw;
    if (g == 0) begin : g_b
      assign bxw = '0; assign byw = '0; assign biw = '0; assign baw = 1'b0;
      assign bvw = 1'b1;
    end else begin : g_n
      assign bxw = cx[g-1]; assign byw = cy[g-1];
      assign biw = ci[g-1]; assign baw = ca[g-1];
      assign bvw = cv[g-1];
    end
    chmc_cell #(.CW(CW)) u_cell (
      .clk, .rst_n, .load, .clear(clr),
      .new_x(in_ch.point_x[CW-1:0]), .new_y(in_ch.point_y[CW-1:0]),
      .new_idx(IDX_W'(cnt_r)), .below_valid(bvw), .below_after(baw), .below_x(bxw),
      .below_y(byw), .below_idx(biw), .after_o(ca[g]), .x_o(cx[g]),
      .y_o(cy[g]), .idx_o(ci[g]), .valid_o(cv[g])
    );
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sx_r[cnt_r[PI_W-1:0]] <= in_ch.point_x[CW-1:0];
      sy_r[cnt_r[PI_W-1:0]] <= in_ch.point_y[CW-1:0];
    end
  end

  assign in_ch.ready = (state_r == S_LOAD);

  // candidate point and stack top two
  logic [PI_W-1:0] p_w, o_w, a_w;
  logic [SP_W-1:0] km1, km2;
  logic            need_pop;
  assign p_w = ci[i_r[PI_W-1:0]][PI_W-1:0];
  assign km1 = k_r - SP_W'(1);
  assign km2 = k_r - SP_W'(2);
  assign need_pop = upper_r ? (k_r >= bound_r) : (k_r >= SP_W'(2));

  // stack memory: port 0 serves the emit pointer while results go out
  logic [SP_W-1:0] e_nxt;
  logic [SA_W-1:0] rd0_addr;
  logic [PI_W-1:0] rd0_r, rd1_r;

  always_comb begin
    e_nxt = e_r;
    if (state_r == S_EMIT) e_nxt = '0;
    else if (state_r == S_OUT && out_ch.ready && !out_ch.last_result)
      e_nxt = e_r + SP_W'(1);
  end

  assign rd0_addr = (state_r == S_OUT || state_r == S_EMIT) ? e_nxt[SA_W-1:0]
                                                            : km2[SA_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT) stk_r[k_r[SA_W-1:0]] <= p_w;
    rd0_r <= stk_r[rd0_addr];
    rd1_r <= stk_r[km1[SA_W-1:0]];
  end

  assign o_w = rd0_r;
  assign a_w = rd1_r;

  // the row is cleared as the last result word is taken
  assign clr = (state_r == S_OUT) && out_ch.ready && out_ch.last_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0;
    end else begin
      e_r <= e_nxt;
      unique case (state_r)
        S_LOAD: begin
          if (in_ch.valid) begin
            if (load) cnt_r <= cnt_r + CNT_W'(1);
            else ovf_r <= 1'b1;
            if (in_ch.last_point) begin
              k_r <= '0; upper_r <= 1'b0; i_r <= '0;
              if ((load ? cnt_r + CNT_W'(1) : cnt_r) < CNT_W'(2)) begin
                empty_r <= 1'b1;
                if (!load) ovf_r <= 1'b1;
                state_r <= S_OUT;
              end else begin
                empty_r <= 1'b0;
                state_r <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          if (need_pop) begin
            ax_r <= (CW+1)'(sx_r[a_w]) - (CW+1)'(sx_r[o_w]);
            ay_r <= (CW+1)'(sy_r[a_w]) - (CW+1)'(sy_r[o_w]);
            bx_r <= (CW+1)'(sx_r[p_w]) - (CW+1)'(sx_r[o_w]);
            by_r <= (CW+1)'(sy_r[p_w]) - (CW+1)'(sy_r[o_w]);
            state_r <= S_MUL;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_MUL: begin
          p1_r <= ax_r * by_r;
          p2_r <= ay_r * bx_r;
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (p1_r < p2_r) begin
            k_r <= km1; state_r <= S_RD;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          k_r <= k_r + SP_W'(1);
          state_r <= S_RD;
          if (!upper_r) begin
            if (i_r == cnt_r - CNT_W'(1)) begin
              upper_r <= 1'b1; bound_r <= k_r + SP_W'(2);
              i_r <= cnt_r - CNT_W'(2);
            end else i_r <= i_r + CNT_W'(1);
          end else if (i_r == '0) begin
            state_r <= S_OUT;
          end else i_r <= i_r - CNT_W'(1);
        end
        // stack top two are read for the new depth
        S_RD: begin
          state_r <= S_FETCH;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (empty_r || e_r == k_r - SP_W'(2)) begin
              state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  logic [PI_W-1:0] q_w;
  assign q_w = rd0_r;
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.hull_x      = empty_r ? '0 : 16'(sx_r[q_w]);
  assign out_ch.hull_y      = empty_r ? '0 : 16'(sy_r[q_w]);
  assign out_ch.hull_index  = empty_r ? '0 : IDX_W'(q_w);
  assign out_ch.hull_empty  = empty_r;
  assign out_ch.overflow    = ovf_r;
  assign out_ch.last_result = empty_r || (e_r == k_r - SP_W'(2));
endmodule

// File: design/chmc_cell.sv
// ---------------------------------------------------------------------------
// chmc_cell
// one slot of the sorted point row: compares the new point and shifts up
// ---------------------------------------------------------------------------
module chmc_cell #(
  parameter int CW = chmc_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       clear,
  input  logic signed [CW-1:0]       new_x,
  input  logic signed [CW-1:0]       new_y,
  input  logic [chmc_pkg::IDX_W-1:0] new_idx,
  input  logic                       below_valid,  // lower neighbour holds a point
  input  logic                       below_after,  // lower neighbour holds a later point
  input  logic signed [CW-1:0]       below_x,
  input  logic signed [CW-1:0]       below_y,
  input  logic [chmc_pkg::IDX_W-1:0] below_idx,
  output logic                       after_o,      // this slot holds a point after new
  output logic signed [CW-1:0]       x_o,
  output logic signed [CW-1:0]       y_o,
  output logic [chmc_pkg::IDX_W-1:0] idx_o,
  output logic                       valid_o
);
  import chmc_pkg::*;

  logic signed [CW-1:0] x_r, y_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 valid_r;
  logic                 fill;
  cell_ctl_t            ctl;

  assign after_o = valid_r && ((x_r > new_x) || (x_r == new_x && y_r > new_y));

  // a free slot fills only if it is the first free one (lower neighbour valid)
  assign fill      = load && !valid_r && below_valid;
  assign ctl.shift = (load && after_o) || fill;
  assign ctl.clear = clear;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r <= 1'b0;
    end else if (fill) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      if (below_after) begin
        x_r <= below_x; y_r <= below_y; idx_r <= below_idx;
      end else begin
        x_r <= new_x; y_r <= new_y; idx_r <= new_idx;
      end
    end
  end

  assign x_o     = x_r;
  assign y_o     = y_r;
  assign idx_o   = idx_r;
  assign valid_o = valid_r;
endmodule

// File: design/chmc_check.sv
// ---------------------------------------------------------------------------
// chmc_check
// port-level checks on the hull block
// ---------------------------------------------------------------------------
module chmc_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_empty,
  input logic out_last
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and emit overlap");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last) else $error("empty word not last");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("word dropped");
endmodule

bind convex_hull_monotone_chain chmc_check u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_empty(out_ch.hull_empty), .out_last(out_ch.last_result)
);
